// ===== rtl/srep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srep_pkg
// Shared constants, the degree-unit arctangent table and the rounding helper
// for the spherical ray endpoint core.
// ----------------------------------------------------------------------------
package srep_pkg;

    localparam int ANGLE_W          = 17;
    localparam int LEN_W            = 16;
    localparam int XY_W             = 33;
    localparam int Z_W              = 29;
    localparam int RND_W            = 67;
    localparam int TABLE_SIZE       = 24;
    localparam int ANGLE_UP_SHIFT   = 13;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 16;

    localparam logic signed [ANGLE_W:0] FULL_TURN    = 18'sd46080;
    localparam logic signed [ANGLE_W:0] HALF_TURN    = 18'sd23040;
    localparam logic signed [ANGLE_W:0] QUARTER_TURN = 18'sd11520;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN  = 33'sd652032874;

    function automatic logic signed [Z_W-1:0] atan_q20(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 29'sd47185920;
            1:       v = 29'sd27855475;
            2:       v = 29'sd14718068;
            3:       v = 29'sd7471121;
            4:       v = 29'sd3750058;
            5:       v = 29'sd1876857;
            6:       v = 29'sd938658;
            7:       v = 29'sd469357;
            8:       v = 29'sd234682;
            9:       v = 29'sd117342;
            10:      v = 29'sd58671;
            11:      v = 29'sd29335;
            12:      v = 29'sd14668;
            13:      v = 29'sd7334;
            14:      v = 29'sd3667;
            15:      v = 29'sd1833;
            16:      v = 29'sd917;
            17:      v = 29'sd458;
            18:      v = 29'sd229;
            19:      v = 29'sd115;
            20:      v = 29'sd57;
            21:      v = 29'sd29;
            22:      v = 29'sd14;
            23:      v = 29'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Rounds v / 2^sh half away from zero.
    function automatic logic signed [RND_W-1:0] round_away(
        input logic signed [RND_W-1:0] v,
        input int                      sh
    );
        logic signed [RND_W-1:0] mag;
        logic signed [RND_W-1:0] q;
        mag = (v < 0) ? -v : v;
        q   = (mag + (RND_W'(1) <<< (sh - 1))) >>> sh;
        return (v < 0) ? -q : q;
    endfunction

endpackage

// ===== rtl/spherical_ray_endpoint_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_ray_endpoint_core
// End point of a ray: start + round(length * direction), with sine and cosine
// from pipelined degree-unit CORDIC lanes and saturation of each coordinate.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_*      in         heading, elevation, start_x, start_y, start_z, length
// m_*      out        end_x, end_y, end_z in tdata; clipped in tuser
//
// One transaction per cycle is accepted while the output is not stalled; there
// are min(CORDIC_STEPS, 24) + 8 register stages, one per CORDIC step plus eight
// for angle reduction, the quarter-turn fold, the sign fold, the two multiplies,
// the two roundings and the final add. The first stage loads at the accepting
// edge, and the result is taken from the final-add stage.
// Reset clears only the stage valid bits.
// A stage holds while its successor is full and stalled, so bubbles close up.
// ----------------------------------------------------------------------------
module spherical_ray_endpoint_core #(
    parameter int CORDIC_STEPS = srep_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_WIDTH  = srep_pkg::COORD_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // heading, elevation, start_x, start_y, start_z, length, zero fill
    input  logic [((50 + 3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // end_x, end_y, end_z, zero fill
    output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,
    // clipped
    output logic [0:0]                                    m_tuser
);

    localparam int N       = (CORDIC_STEPS < srep_pkg::TABLE_SIZE) ?
                             CORDIC_STEPS : srep_pkg::TABLE_SIZE;
    localparam int S       = N + 8;
    localparam int ST_FLIP = N + 2;
    localparam int ST_MUL1 = N + 3;
    localparam int ST_RND1 = N + 4;
    localparam int ST_MUL2 = N + 5;
    localparam int ST_RND2 = N + 6;
    localparam int ST_OUT  = N + 7;
    localparam int AW      = srep_pkg::ANGLE_W;
    localparam int XW      = srep_pkg::XY_W;
    localparam int ZW      = srep_pkg::Z_W;
    localparam int RW      = srep_pkg::RND_W;
    localparam int LW      = srep_pkg::LEN_W;
    localparam int FW      = 34;
    localparam int OW      = LW + 1 + FW;
    localparam int DW      = 18;
    localparam int SUM_W   = COORD_WIDTH + 19;
    localparam int OUT_W   = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int SX_LSB  = 2 * AW;
    localparam int LEN_LSB = 2 * AW + 3 * COORD_WIDTH;

    localparam logic signed [SUM_W-1:0] COORD_HI =
        $signed({{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] COORD_LO = -COORD_HI - SUM_W'(1);

    logic [S-1:0] v_reg;
    logic [S:0]   en;

    always_comb
    begin
        en[S] = m_tready;
        for (int i = S - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < S; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[S-1];

    // Carried fields.
    logic signed [COORD_WIDTH-1:0] sx_reg [ST_OUT];
    logic signed [COORD_WIDTH-1:0] sy_reg [ST_OUT];
    logic signed [COORD_WIDTH-1:0] sz_reg [ST_OUT];
    logic        [LW-1:0]          len_reg [ST_MUL2];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sx_reg[0]  <= s_tdata[SX_LSB +: COORD_WIDTH];
            sy_reg[0]  <= s_tdata[SX_LSB + COORD_WIDTH +: COORD_WIDTH];
            sz_reg[0]  <= s_tdata[SX_LSB + 2 * COORD_WIDTH +: COORD_WIDTH];
            len_reg[0] <= s_tdata[LEN_LSB +: LW];
        end
        for (int i = 1; i < ST_OUT; i++)
        begin
            if (en[i])
            begin
                sx_reg[i] <= sx_reg[i-1];
                sy_reg[i] <= sy_reg[i-1];
                sz_reg[i] <= sz_reg[i-1];
            end
        end
        for (int i = 1; i < ST_MUL2; i++)
        begin
            if (en[i])
            begin
                len_reg[i] <= len_reg[i-1];
            end
        end
    end

    // Angle reduction: modulo a full turn, then into [-180, 180).
    logic signed [AW-1:0] ang_in [2];
    logic signed [AW:0]   wrap_next [2];
    logic signed [AW:0]   r_reg [2];

    assign ang_in[0] = s_tdata[0 +: AW];
    assign ang_in[1] = s_tdata[AW +: AW];

    always_comb
    begin
        logic signed [AW:0] m;
        for (int l = 0; l < 2; l++)
        begin
            m = {ang_in[l][AW-1], ang_in[l]};
            if (m >= srep_pkg::FULL_TURN)
            begin
                m = m - srep_pkg::FULL_TURN;
            end
            else if (m <= -srep_pkg::FULL_TURN)
            begin
                m = m + srep_pkg::FULL_TURN;
            end
            wrap_next[l] = m;
            if (m >= srep_pkg::HALF_TURN)
            begin
                wrap_next[l] = m - srep_pkg::FULL_TURN;
            end
            else if (m < -srep_pkg::HALF_TURN)
            begin
                wrap_next[l] = m + srep_pkg::FULL_TURN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg <= wrap_next;
        end
    end

    // Quarter-turn fold and CORDIC lanes; index k holds stage 1 + k.
    logic signed [XW-1:0] x_reg    [2][N+1];
    logic signed [XW-1:0] y_reg    [2][N+1];
    logic signed [ZW-1:0] z_reg    [2][N+1];
    logic                 flip_reg [2][N+1];

    always_ff @(posedge clk)
    begin
        logic signed [AW:0] q;
        logic               f;
        if (en[1])
        begin
            for (int l = 0; l < 2; l++)
            begin
                q = r_reg[l];
                f = 1'b0;
                if (r_reg[l] > srep_pkg::QUARTER_TURN)
                begin
                    q = r_reg[l] - srep_pkg::HALF_TURN;
                    f = 1'b1;
                end
                else if (r_reg[l] < -srep_pkg::QUARTER_TURN)
                begin
                    q = r_reg[l] + srep_pkg::HALF_TURN;
                    f = 1'b1;
                end
                x_reg[l][0]    <= srep_pkg::CORDIC_GAIN;
                y_reg[l][0]    <= '0;
                z_reg[l][0]    <= ZW'(q) <<< srep_pkg::ANGLE_UP_SHIFT;
                flip_reg[l][0] <= f;
            end
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (en[2 + k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    if (z_reg[l][k] >= 0)
                    begin
                        x_reg[l][k+1] <= x_reg[l][k] - (y_reg[l][k] >>> k);
                        y_reg[l][k+1] <= y_reg[l][k] + (x_reg[l][k] >>> k);
                        z_reg[l][k+1] <= z_reg[l][k] - srep_pkg::atan_q20(k);
                    end
                    else
                    begin
                        x_reg[l][k+1] <= x_reg[l][k] + (y_reg[l][k] >>> k);
                        y_reg[l][k+1] <= y_reg[l][k] - (x_reg[l][k] >>> k);
                        z_reg[l][k+1] <= z_reg[l][k] + srep_pkg::atan_q20(k);
                    end
                    flip_reg[l][k+1] <= flip_reg[l][k];
                end
            end
        end
    end

    // Sign fold, products, roundings and final add.
    logic signed [XW-1:0]   cos_reg [2];
    logic signed [XW-1:0]   sin_reg [2];
    logic signed [2*XW-1:0] px_reg;
    logic signed [2*XW-1:0] py_reg;
    logic signed [XW-1:0]   se_reg;
    logic signed [FW-1:0]   f_reg [3];
    logic signed [OW-1:0]   o_reg [3];
    logic signed [DW-1:0]   d_reg [3];
    logic signed [COORD_WIDTH-1:0] end_reg [3];
    logic                   clip_reg;

    always_ff @(posedge clk)
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [COORD_WIDTH-1:0] st [3];
        logic                    c;
        if (en[ST_FLIP])
        begin
            for (int l = 0; l < 2; l++)
            begin
                cos_reg[l] <= flip_reg[l][N] ? -x_reg[l][N] : x_reg[l][N];
                sin_reg[l] <= flip_reg[l][N] ? -y_reg[l][N] : y_reg[l][N];
            end
        end
        if (en[ST_MUL1])
        begin
            px_reg <= cos_reg[0] * cos_reg[1];
            py_reg <= sin_reg[0] * cos_reg[1];
            se_reg <= sin_reg[1];
        end
        if (en[ST_RND1])
        begin
            f_reg[0] <= FW'(srep_pkg::round_away(RW'(px_reg), 30));
            f_reg[1] <= FW'(srep_pkg::round_away(RW'(py_reg), 30));
            f_reg[2] <= FW'(se_reg);
        end
        if (en[ST_MUL2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                o_reg[k] <= OW'($signed({1'b0, len_reg[ST_MUL2 - 1]})) * OW'(f_reg[k]);
            end
        end
        if (en[ST_RND2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_reg[k] <= DW'(srep_pkg::round_away(RW'(o_reg[k]), 34));
            end
        end
        if (en[ST_OUT])
        begin
            st[0] = sx_reg[ST_OUT - 1];
            st[1] = sy_reg[ST_OUT - 1];
            st[2] = sz_reg[ST_OUT - 1];
            c = 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum = SUM_W'(st[k]) + SUM_W'(d_reg[k]);
                if (sum > COORD_HI)
                begin
                    sum = COORD_HI;
                    c = 1'b1;
                end
                else if (sum < COORD_LO)
                begin
                    sum = COORD_LO;
                    c = 1'b1;
                end
                end_reg[k] <= COORD_WIDTH'(sum);
            end
            clip_reg <= c;
        end
    end

    assign m_tdata = OUT_W'({end_reg[2], end_reg[1], end_reg[0]});
    assign m_tuser = clip_reg;

    localparam logic signed [COORD_WIDTH-1:0] END_HI = COORD_WIDTH'(COORD_HI);
    localparam logic signed [COORD_WIDTH-1:0] END_LO = COORD_WIDTH'(COORD_LO);

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output stage");

    a_ready_passes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while the output side is ready");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted transaction missing from the first stage");

    a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (end_reg[0] == END_HI) || (end_reg[0] == END_LO) ||
            (end_reg[1] == END_HI) || (end_reg[1] == END_LO) ||
            (end_reg[2] == END_HI) || (end_reg[2] == END_LO))
        else $error("clipped set with no coordinate at a bound");

endmodule

// ===== bench/srep_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srep_checker
// Watches both streams of the ray endpoint core. For each input transaction
// it computes the end point with a degree-unit CORDIC model. Each output
// transaction is compared, field by field, with the oldest queued endpoint.
// ----------------------------------------------------------------------------
module srep_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           checked,
    output int           clip_seen
);

    typedef struct packed {
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] ez;
        logic               clip;
    } endpoint_t;

    endpoint_t endpoint_q[$];

    longint atan_deg[24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7
    };

    function automatic longint round_half_away(longint v, int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0)
            return (v + half) >>> sh;
        return -((-v + half) >>> sh);
    endfunction

    task automatic degree_sin_cos(input longint a, output longint c, output longint s);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        r    = a % 46080;
        x    = 652032874;
        y    = 0;
        flip = 0;
        if (r >= 23040)
            r -= 46080;
        else if (r < -23040)
            r += 46080;
        if (r > 11520)
        begin
            r -= 23040;
            flip = 1;
        end
        else if (r < -11520)
        begin
            r += 23040;
            flip = 1;
        end
        z = r * 8192;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_deg[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_deg[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic signed [15:0] saturate(longint v, ref bit clip);
        if (v > 32767)
        begin
            clip = 1;
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            clip = 1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    task automatic predict_endpoint(input logic [103:0] d, output endpoint_t p);
        longint h;
        longint e;
        longint len;
        longint ch;
        longint sh;
        longint ce;
        longint se;
        longint fx;
        longint fy;
        bit     clip;
        h    = longint'($signed(d[16:0]));
        e    = longint'($signed(d[33:17]));
        len  = longint'(d[97:82]);
        clip = 0;
        degree_sin_cos(h, ch, sh);
        degree_sin_cos(e, ce, se);
        fx   = round_half_away(ch * ce, 30);
        fy   = round_half_away(sh * ce, 30);
        p.ex = saturate(longint'($signed(d[49:34])) + round_half_away(len * fx, 34), clip);
        p.ey = saturate(longint'($signed(d[65:50])) + round_half_away(len * fy, 34), clip);
        p.ez = saturate(longint'($signed(d[81:66])) + round_half_away(len * se, 34), clip);
        p.clip = clip;
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what,
                 $signed(got), $signed(want));
        errors++;
    endtask

    initial
    begin
        errors    = 0;
        checked   = 0;
        pending   = 0;
        clip_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        endpoint_t p;
        endpoint_t w;
        if (!rst_n)
        begin
            endpoint_q.delete();
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_endpoint(s_tdata, p);
                endpoint_q.push_back(p);
                if (p.clip)
                    clip_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                if (endpoint_q.size() == 0)
                begin
                    $display("ERROR at %0t ns: output transaction with nothing queued", $time);
                    errors++;
                end
                else
                begin
                    w = endpoint_q.pop_front();
                    checked++;
                    if (m_tdata[15:0] !== w.ex)
                        report("end_x", m_tdata[15:0], w.ex);
                    if (m_tdata[31:16] !== w.ey)
                        report("end_y", m_tdata[31:16], w.ey);
                    if (m_tdata[47:32] !== w.ez)
                        report("end_z", m_tdata[47:32], w.ez);
                    if (m_tuser[0] !== w.clip)
                        report("clipped", 16'(m_tuser[0]), 16'(w.clip));
                end
            end
            pending = endpoint_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the ray endpoint core: directed angle, length and saturation
// corners, then random rays under four idling patterns on both streams.
// ----------------------------------------------------------------------------
module tb;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [0:0]   m_tuser;
    int           errors;
    int           pending;
    int           checked;
    int           clip_seen;
    int           send_idle;
    int           recv_idle;
    int           quiet_cycles;

    localparam int QUIET_LIMIT = 5000;

    spherical_ray_endpoint_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    srep_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .clip_seen (clip_seen)
    );

    initial
    begin
        clk = 0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("spherical_ray_endpoint_core: mismatch");
            $finish;
        end
    end

    task automatic send_ray(input int h, input int e, input int sx, input int sy,
                            input int sz, input int len);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, 16'(len), 16'(sz), 16'(sy), 16'(sx), 17'(e), 17'(h)};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic int pick_angle();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return ($urandom_range(8) - 4) * 11520 + $urandom_range(2) - 1;
        if (k == 1)
            return $urandom_range(1) ? 46080 : -46080;
        return $urandom_range(92160) - 46080;
    endfunction

    function automatic int pick_coord();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 32767 - $urandom_range(4200);
        if (k == 1)
            return -32768 + $urandom_range(4200);
        return $urandom_range(65535) - 32768;
    endfunction

    function automatic int pick_length();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return $urandom_range(3);
        if (k == 1)
            return 65535 - $urandom_range(3);
        return $urandom_range(65535);
    endfunction

    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        send_idle    = 0;
        recv_idle    = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(46080, -46080, 32767, -32768, 100, 0);
        send_ray(0, 0, 0, 0, 0, 65535);
        send_ray(11520, 0, 0, 0, 0, 65535);
        send_ray(-11520, 0, 0, 0, 0, 65535);
        send_ray(23040, 0, 0, 0, 0, 65535);
        send_ray(-23040, 0, 0, 0, 0, 65535);
        send_ray(0, 11520, 0, 0, 0, 65535);
        send_ray(0, -11520, 0, 0, 0, 65535);
        send_ray(11521, 11519, 0, 0, 0, 40000);
        send_ray(-11521, -11519, 0, 0, 0, 40000);
        send_ray(46080, 46080, 1, 2, 3, 65535);
        send_ray(-46080, 23040, -1, -2, -3, 65535);
        send_ray(0, 0, 32767, 0, 0, 65535);
        send_ray(23040, 0, -32768, 0, 0, 65535);
        send_ray(5760, 0, 0, 32767, 0, 65535);
        send_ray(-5760, 0, 0, -32768, 0, 65535);
        send_ray(0, 11520, 0, 0, 32767, 65535);
        send_ray(0, -11520, 0, 0, -32768, 65535);
        send_ray(5760, 5760, 32767, 32767, 32767, 65535);
        send_ray(-17280, -5760, -32768, -32768, -32768, 65535);
        send_ray(64, 64, 12345, -12345, 7, 8);
        send_ray(34560, -34560, 0, 0, 0, 1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 75; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 75; end
                default: begin send_idle = 19; recv_idle = 19; end
            endcase
            for (int n = 0; n < 475; n++)
                send_ray(pick_angle(), pick_angle(), pick_coord(), pick_coord(),
                         pick_coord(), pick_length());
        end
        s_tvalid <= 1'b0;
        recv_idle = 0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Checked %0d ray endpoints, %0d of them saturated,", checked, clip_seen);
        $display("over four idle and stall patterns on both streams.");
        if (errors == 0)
            $display("spherical_ray_endpoint_core: match");
        else
            $display("spherical_ray_endpoint_core: mismatch");
        $finish;
    end

endmodule
